// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpa assertion failed");
`define BPA_ASSERT_NEVER(lbl, cond) \
  `BPA_ASSERT(lbl, !(cond))
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: sv/bpa_pkg.sv
package bpa_pkg;

  localparam int NumPagesDef = 1024;
  localparam int PageIdW     = 10;
  localparam int TagW        = 8;
  localparam int ResultW     = 16;

  localparam logic [7:0]         ByteFull = 8'hFF;
  localparam logic [2:0]         BitMask  = 3'h7;
  localparam logic [ResultW-1:0] BadPage  = 16'hFFFF;

  localparam logic OpFree = 1'b0;
  localparam logic OpGrab = 1'b1;
  localparam logic StDone = 1'b0;
  localparam logic StFail = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [PageIdW-1:0] page_id;
    logic [TagW-1:0]    tag;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               op_kind;
    logic [ResultW-1:0] result_page;
    logic [TagW-1:0]    tag_out;
  } rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_WR,
    S_SCAN
  } state_e;

  typedef enum logic {
    UOP_CLEAR,
    UOP_SET
  } uop_e;

  typedef struct packed {
    uop_e       op;
    logic [2:0] bit_sel;
  } unit_ctl_t;

  typedef struct packed {
    logic       not_full;
    logic [2:0] free_bit;
    logic [7:0] data;
  } unit_res_t;

  function automatic logic [2:0] lowest_clear(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!v[b]) r = 3'(b);
    end
    return r;
  endfunction

endpackage

// File: sv/bpa_mem.sv
module bpa_mem #(
  parameter int Depth = bpa_pkg::NumPagesDef / 8,
  parameter int AddrW = $clog2(bpa_pkg::NumPagesDef / 8)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bpa_bit_unit.sv
module bpa_bit_unit (
  input  logic                 [7:0] byte_i,
  input  bpa_pkg::unit_ctl_t         ctl_i,
  output bpa_pkg::unit_res_t         res_o
);
  import bpa_pkg::*;

  logic [2:0] low_bit;

  always_comb begin
    low_bit        = lowest_clear(byte_i);
    res_o.not_full = (byte_i != ByteFull);
    res_o.free_bit = low_bit;
    case (ctl_i.op)
      UOP_SET:   res_o.data = byte_i | (8'b1 << low_bit);
      UOP_CLEAR: res_o.data = byte_i & ~(8'b1 << ctl_i.bit_sel);
      default:   res_o.data = byte_i;
    endcase
  end

endmodule

// File: sv/bpa_seq.sv
`include "assert_macros.svh"

module bpa_seq #(
  parameter int NumBytes = bpa_pkg::NumPagesDef / 8,
  parameter int AddrW    = $clog2(bpa_pkg::NumPagesDef / 8)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bpa_pkg::req_t         req_i,
  output logic                  rsp_valid_o,
  output bpa_pkg::rsp_t         rsp_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output logic [7:0]            mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  output bpa_pkg::unit_ctl_t    unit_ctl_o,
  input  bpa_pkg::unit_res_t    unit_res_i
);
  import bpa_pkg::*;

  localparam int               FreeIdxW = PageIdW - 3;
  localparam logic [AddrW-1:0] LastIdx  = AddrW'(NumBytes - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  req_t             req_q, req_d;
  logic             in_range_q, in_range_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [FreeIdxW-1:0] in_idx;

  assign in_idx = req_i.page_id[PageIdW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    in_range_q <= in_range_d;
    rsp_q      <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_d       = req_q;
    in_range_d  = in_range_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = unit_res_i.data;
    mem_raddr_o = idx_q;
    unit_ctl_o.op      = (req_q.mode == OpGrab) ? UOP_SET : UOP_CLEAR;
    unit_ctl_o.bit_sel = req_q.page_id[2:0] & BitMask;

    case (state_q)
      S_CLEAR: begin
        // sweep zeros over the bitmap after reset
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
        idx_d       = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.mode == OpGrab) begin
            idx_d       = '0;
            mem_raddr_o = '0;
            state_d     = S_SCAN;
          end else begin
            in_range_d  = (32'(in_idx) < NumBytes);
            idx_d       = AddrW'(32'(in_idx));
            mem_raddr_o = AddrW'(32'(in_idx));
            state_d     = S_FREE_WR;
          end
        end
      end
      S_FREE_WR: begin
        mem_we_o          = in_range_q;
        rsp_valid_d       = 1'b1;
        rsp_d.status      = StDone;
        rsp_d.op_kind     = OpFree;
        rsp_d.result_page = '0;
        rsp_d.tag_out     = req_q.tag;
        state_d           = S_IDLE;
      end
      S_SCAN: begin
        // read data holds the byte at idx_q
        rsp_d.op_kind = OpGrab;
        rsp_d.tag_out = req_q.tag;
        if (unit_res_i.not_full) begin
          mem_we_o          = 1'b1;
          rsp_valid_d       = 1'b1;
          rsp_d.status      = StDone;
          rsp_d.result_page = ResultW'({idx_q, unit_res_i.free_bit});
          state_d           = S_IDLE;
        end else if (idx_q == LastIdx) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = StFail;
          rsp_d.result_page = BadPage;
          state_d           = S_IDLE;
        end else begin
          idx_d       = idx_q + 1'b1;
          mem_raddr_o = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `BPA_ASSERT(a_rsp_after_work, rsp_valid_q |-> ($past(state_q) == S_FREE_WR || $past(state_q) == S_SCAN))
  `BPA_ASSERT_NEVER(a_no_write_idle, mem_we_o && state_q == S_IDLE)
  `BPA_ASSERT(a_fail_grab_only, rsp_valid_q && rsp_q.status == StFail |-> rsp_q.op_kind == OpGrab && rsp_q.result_page == BadPage)
  `BPA_ASSERT(a_free_rsp, rsp_valid_q && rsp_q.op_kind == OpFree |-> rsp_q.status == StDone && rsp_q.result_page == '0)
  `BPA_ASSERT(a_scan_in_range, state_q == S_SCAN |-> idx_q <= LastIdx)

endmodule

// File: sv/bitmap_page_allocator.sv
// channel   | ports                  | handshake
// ----------+------------------------+-------------------------------------
// request   | start, busy, req_i     | word taken when start && !busy
// response  | rsp_valid_o, rsp_o     | one-cycle strobe, no back-pressure
//
// free: bitmap read, then write and response
// grab: one bitmap byte per cycle through the
//   single read port of the bitmap ram; the response follows in the cycle after the deciding byte
// after reset a clearing pass over all NUM_PAGES/8 bitmap bytes runs with busy high
// the response side cannot stall; a new word may be taken while a response shows
module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NumPagesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bpa_pkg::rsp_t rsp_o
);
  import bpa_pkg::*;

  localparam int NumBytes = NUM_PAGES / 8;
  localparam int AddrW    = (NumBytes > 1) ? $clog2(NumBytes) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  unit_ctl_t        unit_ctl;
  unit_res_t        unit_res;

  bpa_seq #(
    .NumBytes (NumBytes),
    .AddrW    (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .unit_ctl_o  (unit_ctl),
    .unit_res_i  (unit_res)
  );

  bpa_mem #(
    .Depth (NumBytes),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpa_bit_unit u_unit (
    .byte_i (mem_rdata),
    .ctl_i  (unit_ctl),
    .res_o  (unit_res)
  );

endmodule

// File: sim/tb_bitmap_page_allocator.sv
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int NumPages   = NumPagesDef;
  localparam int NumBytes   = NumPages / 8;
  localparam int QuietLimit = 10 * (NumBytes + 10);

  typedef struct {
    req_t w;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  logic [7:0] page_used [NumBytes];
  int         last_grant;
  rsp_t       pending_rsp [$];
  step_row_t  directed_rows [$];
  int         mismatches;
  int         quiet_cycles;

  bitmap_page_allocator #(
    .NUM_PAGES(NumPages)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // first-fit model of the bitmap: lowest non-full byte, then its lowest clear flag
  function automatic rsp_t predict_alloc(input req_t w);
    rsp_t r;
    int   idx;
    int   found;
    int   pos;
    r = '0;
    r.status = StDone;
    r.op_kind = w.mode;
    r.tag_out = w.tag;
    if (w.mode == OpFree) begin
      idx = int'(w.page_id) >> 3;
      if (idx < NumBytes) page_used[idx][w.page_id & BitMask] = 1'b0;
    end else begin
      found = -1;
      pos = -1;
      for (idx = 0; idx < NumBytes; idx++) begin
        if (found < 0 && page_used[idx] != ByteFull) found = idx;
      end
      if (found < 0) begin
        r.status = StFail;
        r.result_page = BadPage;
      end else begin
        for (idx = 0; idx < 8; idx++) begin
          if (pos < 0 && !page_used[found][idx]) pos = idx;
        end
        page_used[found][pos] = 1'b1;
        r.result_page = ResultW'(found * 8 + pos);
        last_grant = found * 8 + pos;
      end
    end
    return r;
  endfunction

  function automatic void add_row(input logic mode, input int page, input int tg,
                                  input bit typed, input logic st, input int pg);
    step_row_t row;
    row.w.mode = mode;
    row.w.page_id = PageIdW'(page);
    row.w.tag = TagW'(tg);
    row.typed = typed;
    row.want.status = st;
    row.want.op_kind = mode;
    row.want.result_page = ResultW'(pg);
    row.want.tag_out = TagW'(tg);
    directed_rows.push_back(row);
  endfunction

  task automatic issue_request(input req_t w, input bit typed, input rsp_t want);
    rsp_t calc;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    calc = predict_alloc(w);
    pending_rsp.push_back(typed ? want : calc);
  endtask

  task automatic maybe_rest(input bit allowed);
    int n;
    if (allowed && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_answered();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_word(input int grab_pct, input bit aim_last);
    req_t w;
    w.tag = TagW'($urandom_range(0, 255));
    w.page_id = PageIdW'($urandom_range(0, (1 << PageIdW) - 1));
    w.mode = ($urandom_range(0, 99) < grab_pct) ? OpGrab : OpFree;
    // give back the page handed out most recently
    if (w.mode == OpFree && aim_last && $urandom_range(0, 2) == 0) begin
      w.page_id = PageIdW'(last_grant);
    end
    issue_request(w, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response word: %p", rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.op_kind !== want.op_kind ||
            rsp_o.result_page !== want.result_page || rsp_o.tag_out !== want.tag_out) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("response mismatch: expected %p, got %p", want, rsp_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int  i;
    bit  gaps_on;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    mismatches = 0;
    quiet_cycles = 0;
    last_grant = 0;
    for (i = 0; i < NumBytes; i++) page_used[i] = 8'h00;

    // empty bitmap: grabs walk up from page 0
    add_row(OpGrab, 0, 8'h00, 1'b1, StDone, 0);
    add_row(OpGrab, 10'h3FF, 8'hFF, 1'b1, StDone, 1);
    add_row(OpFree, 0, 8'h5A, 1'b1, StDone, 0);
    add_row(OpGrab, 0, 8'h01, 1'b1, StDone, 0);
    add_row(OpFree, 10'h3FF, 8'hA5, 1'b1, StDone, 0);
    add_row(OpFree, 1, 8'h3C, 1'b1, StDone, 0);
    add_row(OpFree, 1, 8'hC3, 1'b1, StDone, 0);
    add_row(OpGrab, 0, 8'h80, 1'b1, StDone, 1);
    for (i = 2; i < 8; i++) add_row(OpGrab, i * 37, 8'h40 + i, 1'b1, StDone, i);
    add_row(OpGrab, 0, 8'h7E, 1'b1, StDone, 8);
    add_row(OpFree, 5, 8'h11, 1'b1, StDone, 0);
    add_row(OpGrab, 0, 8'h22, 1'b1, StDone, 5);
    add_row(OpFree, 10'h200, 8'h33, 1'b1, StDone, 0);
    add_row(OpFree, 8, 8'h44, 1'b0, StDone, 0);
    add_row(OpGrab, 0, 8'h55, 1'b0, StDone, 0);
    add_row(OpGrab, 10'h155, 8'h66, 1'b0, StDone, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].want);
      maybe_rest(1'b1);
    end
    wait_all_answered();

    // mostly grabs, so the bitmap fills up and grabs start to fail
    gaps_on = 1'b1;
    for (i = 0; i < 1150; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      random_word(97, 1'b0);
      maybe_rest(gaps_on);
    end
    wait_all_answered();

    // churn near full: long scans, frees of live and idle pages
    for (i = 0; i < 780; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      random_word(50, 1'b1);
      maybe_rest(gaps_on && i < 580);
    end

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (NumBytes + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_mem.sv
sv/bpa_bit_unit.sv
sv/bpa_seq.sv
sv/bitmap_page_allocator.sv
sim/tb_bitmap_page_allocator.sv
